[rtl/mmu_pkg.sv]
// Shared types, constants and codes for the address translation unit.
`default_nettype none
package mmu_pkg;

  localparam int PAGE_BYTES_DEF  = 128;
  localparam int NUM_FRAMES_DEF  = 32;
  localparam int TLB_ENTRIES_DEF = 4;
  localparam int PT_ENTRIES_DEF  = 64;

  localparam int VA_W    = 32;
  localparam int EXC_W   = 3;
  localparam int PA_W    = 12;
  localparam int IDX_W   = 6;
  localparam int EVPN_W  = 25;
  localparam int EFR_W   = 6;
  localparam int LIMIT_W = 7;
  localparam int STAMP_W = 32;

  localparam logic [2:0] EXC_NONE = 3'd0;
  localparam logic [2:0] EXC_ADDR = 3'd1;
  localparam logic [2:0] EXC_MISS = 3'd2;
  localparam logic [2:0] EXC_RO   = 3'd3;
  localparam logic [2:0] EXC_BUS  = 3'd4;

  localparam logic [1:0] MODE_XLATE    = 2'd0;
  localparam logic [1:0] MODE_LOAD_PT  = 2'd1;
  localparam logic [1:0] MODE_LOAD_TLB = 2'd2;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  localparam logic [1:0] CFG_USE_TLB     = 2'd0;
  localparam logic [1:0] CFG_REPLACE_LRU = 2'd1;
  localparam logic [1:0] CFG_TABLE_LIMIT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic look;
    logic scan_start;
    logic scan_step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_last;
  } ctrl_stat_t;

endpackage
`default_nettype wire

[rtl/mmu_ctrl.sv]
// Controller state machine sequencing lookup, frame scan and update.
`default_nettype none
module mmu_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire mmu_pkg::ctrl_stat_t stat,
  output logic                    busy,
  output mmu_pkg::ctrl_cmd_t      cmd
);

  mmu_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mmu_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mmu_pkg::ST_IDLE: if (start) state_next = mmu_pkg::ST_LOOK;
      mmu_pkg::ST_LOOK: state_next = stat.need_scan ? mmu_pkg::ST_SCAN : mmu_pkg::ST_FINISH;
      mmu_pkg::ST_SCAN: if (stat.scan_last) state_next = mmu_pkg::ST_FINISH;
      mmu_pkg::ST_FINISH: state_next = mmu_pkg::ST_IDLE;
      default: state_next = mmu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    unique case (state)
      mmu_pkg::ST_IDLE: begin
        busy = 1'b0;
        cmd.capture = start;
      end
      mmu_pkg::ST_LOOK: begin
        cmd.look = 1'b1;
        cmd.scan_start = stat.need_scan;
      end
      mmu_pkg::ST_SCAN: cmd.scan_step = 1'b1;
      mmu_pkg::ST_FINISH: cmd.finish = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

[rtl/mmu_datapath.sv]
// Datapath holding page table, TLB, frame bookkeeping and the result register.
`default_nettype none
module mmu_datapath #(
  parameter int PAGE_BYTES  = mmu_pkg::PAGE_BYTES_DEF,
  parameter int NUM_FRAMES  = mmu_pkg::NUM_FRAMES_DEF,
  parameter int TLB_ENTRIES = mmu_pkg::TLB_ENTRIES_DEF,
  parameter int PT_ENTRIES  = mmu_pkg::PT_ENTRIES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire mmu_pkg::ctrl_cmd_t          cmd,
  output mmu_pkg::ctrl_stat_t              stat,
  input  wire logic                        use_tlb,
  input  wire logic                        replace_lru,
  input  wire logic [mmu_pkg::LIMIT_W-1:0] table_entries_in_use,
  input  wire logic [1:0]                  mode,
  input  wire logic [mmu_pkg::VA_W-1:0]    virt_addr,
  input  wire logic [1:0]                  access_size,
  input  wire logic                        is_write,
  input  wire logic [mmu_pkg::IDX_W-1:0]   entry_index,
  input  wire logic [mmu_pkg::EVPN_W-1:0]  entry_vpn,
  input  wire logic [mmu_pkg::EFR_W-1:0]   entry_frame,
  input  wire logic                        entry_valid,
  input  wire logic                        entry_read_only,
  output logic                             done,
  output logic [mmu_pkg::EXC_W-1:0]        exception,
  output logic [mmu_pkg::PA_W-1:0]         phys_addr,
  output logic                             page_loaded,
  output logic                             evicted,
  output logic [5:0]                       frame_used,
  output logic [5:0]                       victim_vpn,
  output logic                             old_use,
  output logic                             old_dirty
);

  localparam int OFF_W = $clog2(PAGE_BYTES);
  localparam int FR_W  = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int PT_W  = $clog2(PT_ENTRIES);
  localparam int TLB_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int VPN_W = mmu_pkg::VA_W - OFF_W;
  localparam int CNT_W = $clog2(NUM_FRAMES + 1);
  localparam int EFR_W_L = mmu_pkg::EFR_W;

  // Captured item.
  logic [1:0]                 r_mode;
  logic [mmu_pkg::VA_W-1:0]   r_va;
  logic [1:0]                 r_size;
  logic                       r_wr;
  logic [mmu_pkg::IDX_W-1:0]  r_idx;
  logic [mmu_pkg::EVPN_W-1:0] r_evpn;
  logic [mmu_pkg::EFR_W-1:0]  r_efr;
  logic                       r_ev;
  logic                       r_ero;

  // Page table.
  logic [PT_ENTRIES-1:0]       pt_valid, pt_read_only, pt_use, pt_dirty;
  logic [mmu_pkg::EFR_W-1:0]   pt_frame [PT_ENTRIES];

  // TLB.
  logic [TLB_ENTRIES-1:0]      tlb_valid;
  logic [mmu_pkg::EVPN_W-1:0]  tlb_vpn   [TLB_ENTRIES];
  logic [mmu_pkg::EFR_W-1:0]   tlb_frame [TLB_ENTRIES];
  logic [2:0]                  tlb_flags [TLB_ENTRIES];

  // Frame bookkeeping.
  logic [NUM_FRAMES-1:0]        frame_busy;
  logic [PT_W-1:0]              frame_owner [NUM_FRAMES];
  logic [mmu_pkg::STAMP_W-1:0]  frame_stamp [NUM_FRAMES];
  logic [mmu_pkg::STAMP_W-1:0]  stamp_counter;
  logic [FR_W-1:0]              fifo_pointer;

  // Scan registers.
  logic [CNT_W-1:0]             scan_cnt;
  logic [FR_W-1:0]              best_fr;
  logic [mmu_pkg::STAMP_W-1:0]  best_stamp;
  logic                         free_found;
  logic [FR_W-1:0]              free_fr;

  // Lookup results held from the look cycle.
  logic [2:0]                   l_exc;
  logic                         l_early;
  logic                         l_fault;
  logic [TLB_W-1:0]             l_slot;
  logic [mmu_pkg::EFR_W-1:0]    l_pfr;

  logic [VPN_W-1:0]             vpn;
  logic [OFF_W-1:0]             off;
  logic [PT_W-1:0]              vpn_pt;
  logic                         misaligned;
  logic                         out_range;
  logic                         tlb_hit;
  logic [TLB_W-1:0]             tlb_slot;
  logic [FR_W-1:0]              scan_fr;

  assign vpn    = r_va[mmu_pkg::VA_W-1:OFF_W];
  assign off    = r_va[OFF_W-1:0];
  assign vpn_pt = vpn[PT_W-1:0];
  assign scan_fr = scan_cnt[FR_W-1:0];

  always_comb begin
    misaligned = ((r_size == mmu_pkg::SIZE_WORD) && (r_va[1:0] != 2'b00)) ||
                 ((r_size == mmu_pkg::SIZE_HALF) && r_va[0]);
    if (32'(table_entries_in_use) > 32'(PT_ENTRIES)) begin
      out_range = 32'(vpn) >= 32'(PT_ENTRIES);
    end else begin
      out_range = 32'(vpn) >= 32'(table_entries_in_use);
    end
  end

  always_comb begin
    tlb_hit = 1'b0;
    tlb_slot = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tlb_valid[i] && (32'(tlb_vpn[i]) == 32'(vpn))) begin
        tlb_hit = 1'b1;
        tlb_slot = TLB_W'(i);
      end
    end
  end

  always_comb begin
    stat.need_scan = (r_mode == mmu_pkg::MODE_XLATE) && !misaligned && !use_tlb &&
                     !out_range && !pt_valid[vpn_pt];
    stat.scan_last = (scan_cnt == CNT_W'(NUM_FRAMES - 1));
  end

  // Final-cycle decisions.
  logic [FR_W-1:0]             tgt;
  logic                        fin_evict;
  logic [EFR_W_L-1:0]          fin_frame;
  logic                        fin_ro;
  logic [2:0]                  fin_exc;
  logic                        lru_better;
  logic [PT_W-1:0]             victim_own;

  assign lru_better = frame_stamp[scan_fr] < best_stamp;

  always_comb begin
    fin_evict = 1'b0;
    tgt = free_fr;
    if (l_fault && !free_found) begin
      fin_evict = 1'b1;
      tgt = replace_lru ? best_fr : fifo_pointer;
    end
    victim_own = frame_owner[tgt];
    if (use_tlb) begin
      fin_frame = tlb_frame[l_slot];
      fin_ro = tlb_flags[l_slot][0];
    end else begin
      fin_frame = l_fault ? EFR_W_L'(tgt) : l_pfr;
      fin_ro = pt_read_only[vpn_pt];
    end
    if (l_early) begin
      fin_exc = l_exc;
    end else if (fin_ro && r_wr) begin
      fin_exc = mmu_pkg::EXC_RO;
    end else if ({26'd0, fin_frame} >= 32'(NUM_FRAMES)) begin
      fin_exc = mmu_pkg::EXC_BUS;
    end else begin
      fin_exc = mmu_pkg::EXC_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r_mode <= mode;
      r_va <= virt_addr;
      r_size <= access_size;
      r_wr <= is_write;
      r_idx <= entry_index;
      r_evpn <= entry_vpn;
      r_efr <= entry_frame;
      r_ev <= entry_valid;
      r_ero <= entry_read_only;
    end
    if (cmd.look) begin
      l_fault <= stat.need_scan;
      l_slot <= tlb_slot;
      l_pfr <= pt_frame[vpn_pt];
      l_early <= 1'b1;
      l_exc <= mmu_pkg::EXC_NONE;
      if (r_mode == mmu_pkg::MODE_XLATE) begin
        if (misaligned) begin
          l_exc <= mmu_pkg::EXC_ADDR;
        end else if (!use_tlb && out_range) begin
          l_exc <= mmu_pkg::EXC_ADDR;
        end else if (use_tlb && !tlb_hit) begin
          l_exc <= mmu_pkg::EXC_MISS;
        end else begin
          l_early <= 1'b0;
        end
      end
    end
    if (cmd.scan_start) begin
      scan_cnt <= '0;
      best_fr <= '0;
      best_stamp <= frame_stamp[0];
      free_found <= 1'b0;
      free_fr <= '0;
    end else if (cmd.scan_step) begin
      scan_cnt <= scan_cnt + CNT_W'(1);
      if (!frame_busy[scan_fr] && !free_found) begin
        free_found <= 1'b1;
        free_fr <= scan_fr;
      end
      if (lru_better) begin
        best_stamp <= frame_stamp[scan_fr];
        best_fr <= scan_fr;
      end
    end
  end

  // Table and bookkeeping updates, and the result beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      pt_valid <= '0;
      pt_read_only <= '0;
      pt_use <= '0;
      pt_dirty <= '0;
      tlb_valid <= '0;
      frame_busy <= '0;
      stamp_counter <= '0;
      fifo_pointer <= '0;
      done <= 1'b0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        tlb_vpn[i] <= '0;
        tlb_frame[i] <= '0;
        tlb_flags[i] <= '0;
      end
      for (int i = 0; i < NUM_FRAMES; i++) begin
        frame_owner[i] <= '0;
        frame_stamp[i] <= '0;
      end
    end else begin
      done <= cmd.finish;
      if (cmd.finish) begin
        exception <= mmu_pkg::EXC_NONE;
        phys_addr <= '0;
        page_loaded <= 1'b0;
        evicted <= 1'b0;
        frame_used <= '0;
        victim_vpn <= '0;
        old_use <= 1'b0;
        old_dirty <= 1'b0;
        if (r_mode == mmu_pkg::MODE_LOAD_PT) begin
          if ({26'd0, r_idx} < 32'(PT_ENTRIES)) begin
            old_use <= pt_use[r_idx[PT_W-1:0]];
            old_dirty <= pt_dirty[r_idx[PT_W-1:0]];
            pt_valid[r_idx[PT_W-1:0]] <= r_ev;
            pt_read_only[r_idx[PT_W-1:0]] <= r_ero;
            pt_use[r_idx[PT_W-1:0]] <= 1'b0;
            pt_dirty[r_idx[PT_W-1:0]] <= 1'b0;
            pt_frame[r_idx[PT_W-1:0]] <= r_efr;
          end
        end else if (r_mode == mmu_pkg::MODE_LOAD_TLB) begin
          if ({26'd0, r_idx} < 32'(TLB_ENTRIES)) begin
            old_use <= tlb_flags[r_idx[TLB_W-1:0]][1];
            old_dirty <= tlb_flags[r_idx[TLB_W-1:0]][2];
            tlb_valid[r_idx[TLB_W-1:0]] <= r_ev;
            tlb_vpn[r_idx[TLB_W-1:0]] <= r_evpn;
            tlb_frame[r_idx[TLB_W-1:0]] <= r_efr;
            tlb_flags[r_idx[TLB_W-1:0]] <= {2'b00, r_ero};
          end
        end else if (r_mode == mmu_pkg::MODE_XLATE) begin
          exception <= fin_exc;
          if (!l_early && !use_tlb) begin
            if (l_fault) begin
              page_loaded <= 1'b1;
              frame_used <= 6'(tgt);
              if (fin_evict) begin
                evicted <= 1'b1;
                victim_vpn <= 6'(victim_own);
                pt_valid[victim_own] <= 1'b0;
                if (replace_lru) begin
                  stamp_counter <= stamp_counter + 32'd1;
                  frame_stamp[tgt] <= stamp_counter + 32'd1;
                end else begin
                  fifo_pointer <= (32'(fifo_pointer) + 32'd1 >= 32'(NUM_FRAMES)) ?
                                  '0 : fifo_pointer + FR_W'(1);
                end
              end else begin
                frame_busy[tgt] <= 1'b1;
                stamp_counter <= stamp_counter + 32'd1;
                frame_stamp[tgt] <= stamp_counter + 32'd1;
              end
              frame_owner[tgt] <= vpn_pt;
              pt_frame[vpn_pt] <= EFR_W_L'(tgt);
              pt_valid[vpn_pt] <= 1'b1;
            end else begin
              stamp_counter <= stamp_counter + 32'd1;
              if ({26'd0, l_pfr} < 32'(NUM_FRAMES)) begin
                frame_stamp[l_pfr[FR_W-1:0]] <= stamp_counter + 32'd1;
              end
            end
          end
          if (!l_early && fin_exc == mmu_pkg::EXC_NONE) begin
            phys_addr <= mmu_pkg::PA_W'({fin_frame, off});
            if (use_tlb) begin
              tlb_flags[l_slot] <= tlb_flags[l_slot] | {r_wr, 2'b10};
            end else begin
              pt_use[vpn_pt] <= 1'b1;
              if (r_wr) pt_dirty[vpn_pt] <= 1'b1;
            end
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

[rtl/mmu_translate_with_page_replacement.sv]
// Top level of the address translation unit with frame replacement.
//
//   Channel  Signals                                 Direction
//   item     start, busy, mode .. entry_read_only    in
//   result   done, exception .. old_dirty            out
//   config   cfg_valid, cfg_ready, cfg_index, cfg_data  in
//
// A load or a translation that needs no new frame passes through the look and
// finish states to the done beat. A page fault in page-table mode also passes
// through the scan state, which walks the frame table one frame per cycle.
// Reset clears the flag tables and frame bookkeeping at once; page-table frame
// numbers are always written before they are read. The block is ready in the
// next cycle.
// The receiver cannot stall: each result is shown for one cycle with done.
`default_nettype none
module mmu_translate_with_page_replacement #(
  parameter int PAGE_BYTES  = mmu_pkg::PAGE_BYTES_DEF,
  parameter int NUM_FRAMES  = mmu_pkg::NUM_FRAMES_DEF,
  parameter int TLB_ENTRIES = mmu_pkg::TLB_ENTRIES_DEF,
  parameter int PT_ENTRIES  = mmu_pkg::PT_ENTRIES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  mode,
  input  wire logic [mmu_pkg::VA_W-1:0]    virt_addr,
  input  wire logic [1:0]                  access_size,
  input  wire logic                        is_write,
  input  wire logic [mmu_pkg::IDX_W-1:0]   entry_index,
  input  wire logic [mmu_pkg::EVPN_W-1:0]  entry_vpn,
  input  wire logic [mmu_pkg::EFR_W-1:0]   entry_frame,
  input  wire logic                        entry_valid,
  input  wire logic                        entry_read_only,
  output logic                             done,
  output logic [mmu_pkg::EXC_W-1:0]        exception,
  output logic [mmu_pkg::PA_W-1:0]         phys_addr,
  output logic                             page_loaded,
  output logic                             evicted,
  output logic [5:0]                       frame_used,
  output logic [5:0]                       victim_vpn,
  output logic                             old_use,
  output logic                             old_dirty,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [mmu_pkg::LIMIT_W-1:0] cfg_data
);

  logic                        use_tlb;
  logic                        replace_lru;
  logic [mmu_pkg::LIMIT_W-1:0] table_entries_in_use;
  mmu_pkg::ctrl_cmd_t          cmd;
  mmu_pkg::ctrl_stat_t         stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      use_tlb <= 1'b0;
      replace_lru <= 1'b0;
      table_entries_in_use <= mmu_pkg::LIMIT_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mmu_pkg::CFG_USE_TLB:     use_tlb <= cfg_data[0];
        mmu_pkg::CFG_REPLACE_LRU: replace_lru <= cfg_data[0];
        mmu_pkg::CFG_TABLE_LIMIT: table_entries_in_use <= cfg_data;
        default: use_tlb <= use_tlb;
      endcase
    end
  end

  mmu_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .busy (busy),
    .cmd  (cmd)
  );

  mmu_datapath #(
    .PAGE_BYTES (PAGE_BYTES),
    .NUM_FRAMES (NUM_FRAMES),
    .TLB_ENTRIES(TLB_ENTRIES),
    .PT_ENTRIES (PT_ENTRIES)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .stat                (stat),
    .use_tlb             (use_tlb),
    .replace_lru         (replace_lru),
    .table_entries_in_use(table_entries_in_use),
    .mode                (mode),
    .virt_addr           (virt_addr),
    .access_size         (access_size),
    .is_write            (is_write),
    .entry_index         (entry_index),
    .entry_vpn           (entry_vpn),
    .entry_frame         (entry_frame),
    .entry_valid         (entry_valid),
    .entry_read_only     (entry_read_only),
    .done                (done),
    .exception           (exception),
    .phys_addr           (phys_addr),
    .page_loaded         (page_loaded),
    .evicted             (evicted),
    .frame_used          (frame_used),
    .victim_vpn          (victim_vpn),
    .old_use             (old_use),
    .old_dirty           (old_dirty)
  );

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("start not taken");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done longer than one beat");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");
  a_exc_clean: assert property (@(posedge clk) disable iff (rst)
    (done && exception != mmu_pkg::EXC_NONE) |-> (phys_addr == '0))
    else $error("address given with exception");

endmodule
`default_nettype wire

[verif/tb_mmu_translate_with_page_replacement.sv]
// Self-checking testbench for the address translation unit with frame replacement.
`timescale 1ns / 100ps
module tb_mmu_translate_with_page_replacement;

  typedef struct packed {
    logic [2:0]  exc;
    logic [11:0] pa;
    logic        loaded;
    logic        evict;
    logic [5:0]  fused;
    logic [5:0]  victim;
    logic        ouse;
    logic        odirty;
  } xlate_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] mode = mmu_pkg::MODE_XLATE;
  logic [31:0] virt_addr = '0;
  logic [1:0] access_size = mmu_pkg::SIZE_BYTE;
  logic is_write = 1'b0;
  logic [5:0] entry_index = '0;
  logic [24:0] entry_vpn = '0;
  logic [5:0] entry_frame = '0;
  logic entry_valid = 1'b0;
  logic entry_read_only = 1'b0;
  logic done;
  logic [2:0] exception;
  logic [11:0] phys_addr;
  logic page_loaded, evicted;
  logic [5:0] frame_used, victim_vpn;
  logic old_use, old_dirty;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = mmu_pkg::CFG_USE_TLB;
  logic [6:0] cfg_data = '0;

  mmu_translate_with_page_replacement dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Shadow copy of the translation state.
  bit        sh_use_tlb, sh_lru;
  bit [6:0]  sh_limit;
  bit        pt_valid[64], pt_ro[64], pt_use[64], pt_dirty[64];
  bit [5:0]  pt_frame[64];
  bit        tlb_valid[4];
  bit [24:0] tlb_vpn[4];
  bit [5:0]  tlb_frame[4];
  bit [2:0]  tlb_flags[4];
  bit        frame_busy[32];
  bit [5:0]  frame_owner[32];
  bit [31:0] frame_stamp[32];
  bit [31:0] stamp_counter;
  bit [4:0]  fifo_pointer;

  xlate_result_t expected_xlate[$];
  int errors = 0;
  int n_items = 0, n_faults = 0, n_evicts = 0, n_results = 0;
  int n_exc[5] = '{0, 0, 0, 0, 0};
  int idle_pct = 0;

  task automatic predict_translation(input logic [1:0] m, input logic [31:0] va,
                                     input logic [1:0] sz, input logic wr,
                                     input logic [5:0] idx, input logic [24:0] evpn,
                                     input logic [5:0] efr, input logic ev, input logic ero);
    xlate_result_t r;
    bit [24:0] vpn;
    bit [6:0] off;
    bit [6:0] lim;
    bit ro, go;
    bit [5:0] frame;
    int tgt, slot;
    bit [31:0] best;
    r = '0;
    go = 1'b0;
    slot = -1;
    ro = 1'b0;
    frame = '0;
    vpn = va[31:7];
    off = va[6:0];
    if (m == mmu_pkg::MODE_LOAD_PT) begin
      r.ouse = pt_use[idx];
      r.odirty = pt_dirty[idx];
      pt_valid[idx] = ev;
      pt_ro[idx] = ero;
      pt_use[idx] = 1'b0;
      pt_dirty[idx] = 1'b0;
      pt_frame[idx] = efr;
    end else if (m == mmu_pkg::MODE_LOAD_TLB) begin
      if (idx < 4) begin
        r.ouse = tlb_flags[idx][1];
        r.odirty = tlb_flags[idx][2];
        tlb_valid[idx] = ev;
        tlb_vpn[idx] = evpn;
        tlb_frame[idx] = efr;
        tlb_flags[idx] = {2'b00, ero};
      end
    end else if (m == mmu_pkg::MODE_XLATE) begin
      if ((sz == mmu_pkg::SIZE_WORD && va[1:0] != 2'b00) ||
          (sz == mmu_pkg::SIZE_HALF && va[0])) begin
        r.exc = mmu_pkg::EXC_ADDR;
      end else if (!sh_use_tlb) begin
        lim = (sh_limit > 7'd64) ? 7'd64 : sh_limit;
        if (vpn >= lim) begin
          r.exc = mmu_pkg::EXC_ADDR;
        end else begin
          go = 1'b1;
          if (!pt_valid[vpn]) begin
            tgt = 32;
            for (int i = 0; i < 32; i++)
              if (!frame_busy[i] && tgt == 32) tgt = i;
            if (tgt < 32) begin
              frame_busy[tgt] = 1'b1;
              stamp_counter++;
              frame_stamp[tgt] = stamp_counter;
            end else begin
              if (sh_lru) begin
                best = frame_stamp[0];
                tgt = 0;
                for (int i = 1; i < 32; i++)
                  if (frame_stamp[i] < best) begin
                    best = frame_stamp[i];
                    tgt = i;
                  end
                stamp_counter++;
                frame_stamp[tgt] = stamp_counter;
              end else begin
                tgt = fifo_pointer;
                fifo_pointer++;
              end
              pt_valid[frame_owner[tgt]] = 1'b0;
              r.evict = 1'b1;
              r.victim = frame_owner[tgt];
            end
            frame_owner[tgt] = vpn[5:0];
            pt_frame[vpn] = tgt[5:0];
            pt_valid[vpn] = 1'b1;
            r.loaded = 1'b1;
            r.fused = tgt[5:0];
          end else begin
            stamp_counter++;
            if (pt_frame[vpn] < 6'd32) frame_stamp[pt_frame[vpn]] = stamp_counter;
          end
          ro = pt_ro[vpn];
          frame = pt_frame[vpn];
        end
      end else begin
        for (int i = 0; i < 4; i++)
          if (slot < 0 && tlb_valid[i] && tlb_vpn[i] == vpn) slot = i;
        if (slot < 0) begin
          r.exc = mmu_pkg::EXC_MISS;
        end else begin
          go = 1'b1;
          ro = tlb_flags[slot][0];
          frame = tlb_frame[slot];
        end
      end
      if (go) begin
        if (ro && wr) begin
          r.exc = mmu_pkg::EXC_RO;
        end else if (frame >= 6'd32) begin
          r.exc = mmu_pkg::EXC_BUS;
        end else begin
          if (!sh_use_tlb) begin
            pt_use[vpn] = 1'b1;
            if (wr) pt_dirty[vpn] = 1'b1;
          end else begin
            tlb_flags[slot] = tlb_flags[slot] | 3'b010 | (wr ? 3'b100 : 3'b000);
          end
          r.pa = {frame[4:0], off};
        end
      end
    end
    if (r.loaded) n_faults++;
    if (r.evict) n_evicts++;
    n_exc[r.exc]++;
    expected_xlate.push_back(r);
  endtask

  task automatic send_item(input logic [1:0] m, input logic [31:0] va, input logic [1:0] sz,
                           input logic wr, input logic [5:0] idx, input logic [24:0] evpn,
                           input logic [5:0] efr, input logic ev, input logic ero);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start = 1'b1;
    mode = m;
    virt_addr = va;
    access_size = sz;
    is_write = wr;
    entry_index = idx;
    entry_vpn = evpn;
    entry_frame = efr;
    entry_valid = ev;
    entry_read_only = ero;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    predict_translation(m, va, sz, wr, idx, evpn, efr, ev, ero);
    n_items++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    while (expected_xlate.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    wait_idle();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    case (idx)
      mmu_pkg::CFG_USE_TLB: sh_use_tlb = val[0];
      mmu_pkg::CFG_REPLACE_LRU: sh_lru = val[0];
      mmu_pkg::CFG_TABLE_LIMIT: sh_limit = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [1:0] rand_size();
    return 2'($urandom_range(3));
  endfunction

  // Mostly aligned accesses to a window of pages; now and then a wild address.
  task automatic xlate_rand(input int max_vpn);
    logic [31:0] va;
    logic [1:0] sz;
    sz = rand_size();
    if ($urandom_range(19) == 0) begin
      va = $urandom;
    end else begin
      va = {25'($urandom_range(max_vpn)), 7'($urandom_range(127))};
      if ($urandom_range(9) != 0) begin
        if (sz == mmu_pkg::SIZE_WORD) va[1:0] = 2'b00;
        if (sz == mmu_pkg::SIZE_HALF) va[0] = 1'b0;
      end
    end
    send_item(mmu_pkg::MODE_XLATE, va, sz, 1'($urandom_range(1)), 6'($urandom),
              25'($urandom), 6'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  task automatic load_pt_rand();
    logic [5:0] fr;
    fr = ($urandom_range(5) == 0) ? 6'($urandom_range(32, 63)) : 6'($urandom_range(31));
    send_item(mmu_pkg::MODE_LOAD_PT, $urandom, rand_size(), 1'($urandom_range(1)),
              6'($urandom), 25'($urandom), fr, 1'($urandom_range(1)),
              ($urandom_range(3) == 0));
  endtask

  task automatic test_directed();
    idle_pct = 0;
    send_item(mmu_pkg::MODE_LOAD_PT, '0, mmu_pkg::SIZE_BYTE, 1'b0, 6'd5, '0, 6'd40,
              1'b1, 1'b0);
    send_item(mmu_pkg::MODE_XLATE, {25'd5, 7'd3}, mmu_pkg::SIZE_BYTE, 1'b0, '0, '0, '0,
              1'b0, 1'b0);
    send_item(mmu_pkg::MODE_LOAD_PT, '0, mmu_pkg::SIZE_BYTE, 1'b0, 6'd6, '0, 6'd31,
              1'b1, 1'b1);
    send_item(mmu_pkg::MODE_XLATE, {25'd6, 7'd127}, mmu_pkg::SIZE_BYTE, 1'b1, '0, '0, '0,
              1'b0, 1'b0);
    send_item(mmu_pkg::MODE_XLATE, {25'd6, 7'd127}, mmu_pkg::SIZE_BYTE, 1'b0, '0, '0, '0,
              1'b0, 1'b0);
    send_item(mmu_pkg::MODE_XLATE, {25'd7, 7'd2}, mmu_pkg::SIZE_WORD, 1'b1, '0, '0, '0,
              1'b0, 1'b0);
    send_item(mmu_pkg::MODE_XLATE, {25'd7, 7'd2}, mmu_pkg::SIZE_HALF, 1'b1, '0, '0, '0,
              1'b0, 1'b0);
    send_item(mmu_pkg::MODE_XLATE, {25'd7, 7'd1}, mmu_pkg::SIZE_HALF, 1'b0, '0, '0, '0,
              1'b0, 1'b0);
    send_item(mmu_pkg::MODE_XLATE, {25'd7, 7'd3}, 2'd3, 1'b1, '0, '0, '0, 1'b0, 1'b0);
    send_item(mmu_pkg::MODE_XLATE, 32'hFFFF_FFFF, 2'd3, 1'b1, 6'h3F, 25'h1FF_FFFF, 6'h3F,
              1'b1, 1'b1);
    send_item(mmu_pkg::MODE_XLATE, {25'd63, 7'd0}, mmu_pkg::SIZE_WORD, 1'b0, '0, '0, '0,
              1'b0, 1'b0);
    send_item(mmu_pkg::MODE_XLATE, {25'd64, 7'd0}, mmu_pkg::SIZE_WORD, 1'b0, '0, '0, '0,
              1'b0, 1'b0);
    send_item(mmu_pkg::MODE_LOAD_PT, '0, mmu_pkg::SIZE_BYTE, 1'b0, 6'd7, '0, 6'd0,
              1'b0, 1'b0);
    send_item(2'd3, 32'hFFFF_FFFF, 2'd3, 1'b1, 6'h3F, 25'h1FF_FFFF, 6'h3F, 1'b1, 1'b1);
    send_item(mmu_pkg::MODE_LOAD_TLB, '0, mmu_pkg::SIZE_BYTE, 1'b0, 6'd10, 25'd1, 6'd1,
              1'b1, 1'b0);
    send_item(mmu_pkg::MODE_LOAD_TLB, '0, mmu_pkg::SIZE_BYTE, 1'b0, 6'd3, 25'h1FF_FFFF,
              6'd63, 1'b1, 1'b1);
    send_item(mmu_pkg::MODE_LOAD_TLB, '0, mmu_pkg::SIZE_BYTE, 1'b0, 6'd0, 25'd2, 6'd9,
              1'b1, 1'b0);
    send_item(mmu_pkg::MODE_LOAD_TLB, '0, mmu_pkg::SIZE_BYTE, 1'b0, 6'd1, 25'd4, 6'd12,
              1'b1, 1'b1);
    write_reg(mmu_pkg::CFG_USE_TLB, 7'd1);
    send_item(mmu_pkg::MODE_XLATE, {25'd2, 7'd4}, mmu_pkg::SIZE_WORD, 1'b1, '0, '0, '0,
              1'b0, 1'b0);
    send_item(mmu_pkg::MODE_XLATE, {25'd4, 7'd4}, mmu_pkg::SIZE_WORD, 1'b1, '0, '0, '0,
              1'b0, 1'b0);
    send_item(mmu_pkg::MODE_XLATE, {25'd9, 7'd4}, mmu_pkg::SIZE_WORD, 1'b0, '0, '0, '0,
              1'b0, 1'b0);
    send_item(mmu_pkg::MODE_XLATE, 32'hFFFF_FFFC, mmu_pkg::SIZE_WORD, 1'b0, '0, '0, '0,
              1'b0, 1'b0);
    send_item(mmu_pkg::MODE_LOAD_TLB, '0, mmu_pkg::SIZE_BYTE, 1'b0, 6'd0, 25'd2, 6'd9,
              1'b0, 1'b0);
    write_reg(mmu_pkg::CFG_USE_TLB, 7'd0);
  endtask

  task automatic test_page_table(input bit lru, input int count);
    write_reg(mmu_pkg::CFG_REPLACE_LRU, {6'd0, lru});
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) idle_pct = (i / 60) % 4 == 0 ? 0 : (i / 60) % 4 == 1 ? 83 : 6;
      if ($urandom_range(14) == 0) load_pt_rand();
      else xlate_rand(lru ? 50 : 47);
    end
  endtask

  task automatic test_tlb(input int count);
    write_reg(mmu_pkg::CFG_USE_TLB, 7'd1);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) idle_pct = (i / 50) % 3 == 0 ? 0 : (i / 50) % 3 == 1 ? 83 : 6;
      if ($urandom_range(3) == 0)
        send_item(mmu_pkg::MODE_LOAD_TLB, $urandom, rand_size(), 1'($urandom_range(1)),
                  ($urandom_range(7) == 0) ? 6'($urandom) : 6'($urandom_range(3)),
                  ($urandom_range(9) == 0) ? 25'($urandom) : 25'($urandom_range(7)),
                  ($urandom_range(4) == 0) ? 6'($urandom) : 6'($urandom_range(31)),
                  ($urandom_range(4) != 0), 1'($urandom_range(1)));
      else
        xlate_rand(9);
    end
    write_reg(mmu_pkg::CFG_USE_TLB, 7'd0);
  endtask

  task automatic test_table_limit();
    logic [6:0] lims[5];
    lims = '{7'd0, 7'd1, 7'd40, 7'd100, 7'd64};
    foreach (lims[k]) begin
      write_reg(mmu_pkg::CFG_TABLE_LIMIT, lims[k]);
      idle_pct = k * 20;
      for (int i = 0; i < 30; i++) begin
        if ($urandom_range(9) == 0) load_pt_rand();
        else xlate_rand(70);
      end
    end
  endtask

  initial begin
    sh_use_tlb = 1'b0;
    sh_lru = 1'b0;
    sh_limit = 7'd64;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_page_table(1'b0, 350);
    wait_idle();
    test_page_table(1'b1, 350);
    test_page_table(1'b0, 100);
    test_tlb(250);
    test_table_limit();
    wait_idle();
    repeat (50) @(negedge clk);
    $display("Sent %0d items: %0d page faults, %0d evictions, FIFO and LRU victims,",
             n_items, n_faults, n_evicts);
    $display("exceptions none/addr/miss/ro/bus = %0d/%0d/%0d/%0d/%0d, %0d results checked.",
             n_exc[0], n_exc[1], n_exc[2], n_exc[3], n_exc[4], n_results);
    if (errors == 0 && expected_xlate.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  always @(posedge clk) begin : result_check
    xlate_result_t e, a;
    if (!rst && done) begin
      a = '{exception, phys_addr, page_loaded, evicted, frame_used, victim_vpn,
            old_use, old_dirty};
      n_results++;
      if (expected_xlate.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, a);
        errors++;
      end else begin
        e = expected_xlate.pop_front();
        if (a !== e) begin
          errors++;
          $display("%0t: mismatch exp exc=%0d pa=%h ld=%b ev=%b fr=%0d vic=%0d ou=%b od=%b",
                   $time, e.exc, e.pa, e.loaded, e.evict, e.fused, e.victim, e.ouse, e.odirty);
          $display("%0t:          act exc=%0d pa=%h ld=%b ev=%b fr=%0d vic=%0d ou=%b od=%b",
                   $time, a.exc, a.pa, a.loaded, a.evict, a.fused, a.victim, a.ouse, a.odirty);
        end
      end
    end
  end

endmodule
